>>> rtl/core/lzw_variable_width_encoder_assert.svh
// assertion macros for the lzw encoder checker
// expects clk and arst_n in the scope where a macro is used
`ifndef LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_ASSERT_SVH

// same-cycle implication, quiet while in reset
`define LZWVE_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lzwve assertion failed");

// next-cycle implication, quiet while in reset
`define LZWVE_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lzwve assertion failed");

`endif

>>> rtl/core/lzwve_pkg.sv
// shared constants and types for the lzw variable-width encoder
// no dependencies
package lzwve_pkg;

	localparam int MAX_CODES_DEF   = 4096;
	localparam int FIRST_WIDTH     = 9;
	localparam int FIRST_FREE_CODE = 257;
	localparam int CODE_W          = 12;
	localparam int CWIDTH_W        = 4;
	localparam int EPOCH_W         = 4;

	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [CWIDTH_W-1:0] code_width;
		logic                last_code;
	} out_item_t;

	// up to three result beats produced by one input byte, item 0 first
	typedef struct packed {
		logic [1:0]      count;
		out_item_t [2:0] item;
	} push_t;

endpackage

>>> rtl/core/lzwve_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module lzwve_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/lzwve_outq.sv
// four-entry result queue, takes up to three beats at once, gives one a cycle while code_stall is low
// depends on lzwve_pkg
module lzwve_outq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lzwve_pkg::push_t               push,
	output logic                           room,
	output logic                           code_valid,
	input  logic                           code_stall,
	output logic [lzwve_pkg::CODE_W-1:0]   code,
	output logic [lzwve_pkg::CWIDTH_W-1:0] code_width,
	output logic                           last_code
);

	lzwve_pkg::out_item_t fifo_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop        = (cnt_q != 3'd0) && !code_stall;
	assign code_valid = (cnt_q != 3'd0);
	// a whole byte's worth of beats must fit
	assign room       = (cnt_q <= 3'd1);
	assign code       = fifo_q[rd_ptr_q].code;
	assign code_width = fifo_q[rd_ptr_q].code_width;
	assign last_code  = fifo_q[rd_ptr_q].last_code;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push.count) begin
				fifo_q[wr_ptr_q + 2'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.count;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + 3'(push.count) - 3'(pop);
		end
	end

endmodule

>>> rtl/core/lzw_variable_width_encoder.sv
// lzw encoder with variable code width, one byte in, zero to three codes out
// depends on lzwve_pkg, lzwve_ram, lzwve_outq
//
// Input channel: byte_valid / byte_stall carry data_byte and end_of_input.
// Output channel: code_valid / code_stall carry code, code_width, last_code.
// The dictionary lives in a hash table ram of 2*MAX_CODES entries, searched
// by linear probing; each entry holds an epoch tag, the (prefix, byte) key
// and the code. Each item reads its ram slot, then compares and writes back
// a new entry, with a further read for each extra probe.
// Results enter a four-entry queue once the lookup is done. A byte is taken
// only while the queue has room for three beats, so a stalled receiver
// backs up into byte_stall.
// Clearing the dictionary bumps the epoch tag; when the tag runs out, and
// after reset, a sweep over all 2*MAX_CODES entries wipes the ram, during which
// byte_stall stays high. The end code closes a stream and the next byte
// starts afresh with an empty dictionary.
module lzw_variable_width_encoder #(
	parameter int MAX_CODES = lzwve_pkg::MAX_CODES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           end_of_input,
	output logic                           code_valid,
	input  logic                           code_stall,
	output logic [lzwve_pkg::CODE_W-1:0]   code,
	output logic [lzwve_pkg::CWIDTH_W-1:0] code_width,
	output logic                           last_code
);

	localparam int CW        = $clog2(MAX_CODES);
	localparam int NW        = CW + 1;
	localparam int HW        = CW + 1;
	localparam int TBL_DEPTH = 1 << HW;
	localparam int WW        = $clog2(CW + 1);
	localparam int KEY_W     = CW + 8;
	localparam int EW        = lzwve_pkg::EPOCH_W;
	localparam int ENT_W     = EW + KEY_W + CW;
	localparam int OUT_W     = lzwve_pkg::CODE_W;
	localparam int OWID_W    = lzwve_pkg::CWIDTH_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0]       state_q;
	logic [HW-1:0]    clr_idx_q;
	logic [EW-1:0]    epoch_q;
	logic [CW-1:0]    prefix_q;
	logic [NW-1:0]    nfc_q;
	logic [WW-1:0]    width_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic [HW-1:0]    probe_q;

	logic             room;
	logic             accept;
	logic [HW-1:0]    hash_idx;
	logic             ram_we;
	logic [HW-1:0]    ram_waddr;
	logic [ENT_W-1:0] ram_wdata;
	logic             ram_re;
	logic [HW-1:0]    ram_raddr;
	logic [ENT_W-1:0] ram_rdata;

	logic [EW-1:0]    rd_epoch;
	logic [KEY_W-1:0] rd_key;
	logic [CW-1:0]    rd_code;
	logic [KEY_W-1:0] key_cur;
	logic             root;
	logic             slot_live;
	logic             slot_match;
	logic             in_lookup;
	logic             probe_again;
	logic             miss;
	logic             done;
	logic [CW-1:0]    byte_code;
	logic [CW-1:0]    prefix_new;
	logic [NW-1:0]    nfc_inc;
	logic             grow;
	logic             full;
	logic [WW-1:0]    width_new;
	logic             do_clear;
	lzwve_pkg::push_t push;

	assign accept     = byte_valid && !byte_stall;
	assign byte_stall = !((state_q == ST_IDLE) && room);

	// root children never reach the table, so the hash only spreads real prefixes
	assign hash_idx = {1'b0, prefix_q} ^ {data_byte, {(HW-8){1'b0}}};

	assign {rd_epoch, rd_key, rd_code} = ram_rdata;
	assign key_cur    = {prefix_q, byte_q};
	assign root       = (prefix_q == '0);
	assign slot_live  = (rd_epoch == epoch_q);
	assign slot_match = slot_live && (rd_key == key_cur);

	assign in_lookup   = (state_q == ST_LOOKUP);
	assign probe_again = in_lookup && !root && slot_live && !slot_match;
	assign miss        = in_lookup && !root && !slot_live;
	assign done        = in_lookup && !probe_again;

	assign byte_code  = CW'({1'b0, byte_q}) + CW'(1);
	assign prefix_new = (root || miss) ? byte_code : rd_code;
	assign nfc_inc    = nfc_q + NW'(1);
	assign grow       = (nfc_inc == (NW'(1) << width_q));
	assign full       = (nfc_inc == NW'(MAX_CODES));
	assign do_clear   = done && ((miss && full) || last_q);

	always_comb begin
		width_new = width_q;
		if (miss) begin
			if (full) begin
				width_new = WW'(lzwve_pkg::FIRST_WIDTH);
			end else if (grow) begin
				width_new = width_q + WW'(1);
			end
		end
	end

	// ram port usage: sweep or new entry on write, first read at accept then probes
	assign ram_re    = accept || probe_again;
	assign ram_raddr = accept ? hash_idx : probe_q + HW'(1);
	assign ram_we    = (state_q == ST_CLEAR) || miss;
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_idx_q : probe_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : {epoch_q, key_cur, nfc_q[CW-1:0]};

	always_comb begin
		push = '0;
		if (done) begin
			if (miss) begin
				push.count              = 2'd1;
				push.item[0].code       = OUT_W'(prefix_q);
				push.item[0].code_width = OWID_W'(width_q);
				push.item[0].last_code  = 1'b0;
				if (last_q) begin
					push.count              = 2'd3;
					push.item[1].code       = OUT_W'(prefix_new);
					push.item[1].code_width = OWID_W'(width_new);
					push.item[1].last_code  = 1'b0;
					push.item[2].code       = '0;
					push.item[2].code_width = OWID_W'(width_new);
					push.item[2].last_code  = 1'b1;
				end
			end else if (last_q) begin
				push.count              = 2'd2;
				push.item[0].code       = OUT_W'(prefix_new);
				push.item[0].code_width = OWID_W'(width_q);
				push.item[0].last_code  = 1'b0;
				push.item[1].code       = '0;
				push.item[1].code_width = OWID_W'(width_q);
				push.item[1].last_code  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q  <= data_byte;
			last_q  <= end_of_input;
			probe_q <= hash_idx;
		end else if (probe_again) begin
			probe_q <= probe_q + HW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			epoch_q   <= EW'(1);
			prefix_q  <= '0;
			nfc_q     <= NW'(lzwve_pkg::FIRST_FREE_CODE);
			width_q   <= WW'(lzwve_pkg::FIRST_WIDTH);
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + HW'(1);
					if (clr_idx_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (done) begin
						prefix_q <= last_q ? '0 : prefix_new;
						if (do_clear) begin
							nfc_q   <= NW'(lzwve_pkg::FIRST_FREE_CODE);
							width_q <= WW'(lzwve_pkg::FIRST_WIDTH);
							// tag space used up: wipe the table, tag 0 marks empty
							if (epoch_q == '1) begin
								epoch_q <= EW'(1);
								state_q <= ST_CLEAR;
							end else begin
								epoch_q <= epoch_q + EW'(1);
								state_q <= ST_IDLE;
							end
						end else begin
							state_q <= ST_IDLE;
							width_q <= width_new;
							if (miss) begin
								nfc_q <= nfc_inc;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	lzwve_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lzwve_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code      (code),
		.code_width(code_width),
		.last_code (last_code)
	);

endmodule

>>> rtl/core/lzwve_checker.sv
// port-level checks for the lzw encoder, bound to the top level
// depends on lzwve_pkg and lzw_variable_width_encoder_assert.svh
`include "lzw_variable_width_encoder_assert.svh"

module lzwve_checker #(
	parameter int MAX_CODES = lzwve_pkg::MAX_CODES_DEF
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           code_valid,
	input logic                           code_stall,
	input logic [lzwve_pkg::CODE_W-1:0]   code,
	input logic [lzwve_pkg::CWIDTH_W-1:0] code_width,
	input logic                           last_code
);

	localparam int CW     = $clog2(MAX_CODES);
	localparam int OWID_W = lzwve_pkg::CWIDTH_W;

	// a stalled beat holds
	`LZWVE_ASSERT_NXT(a_out_hold, code_valid && code_stall, code_valid && $stable(code) && $stable(code_width) && $stable(last_code))

	// code 0 only ever closes a stream, prefixes are never the root
	`LZWVE_ASSERT_IMP(a_end_code, code_valid, (MAX_CODES > 4096) || ((code == '0) == last_code))

	// width stays between the first width and the widest code
	`LZWVE_ASSERT_IMP(a_width_range, code_valid, (MAX_CODES > 32768) || ((code_width >= OWID_W'(lzwve_pkg::FIRST_WIDTH)) && (code_width <= OWID_W'(CW))))

endmodule

bind lzw_variable_width_encoder lzwve_checker #(
	.MAX_CODES(MAX_CODES)
) u_lzwve_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.code_valid(code_valid),
	.code_stall(code_stall),
	.code      (code),
	.code_width(code_width),
	.last_code (last_code)
);

>>> sim/lzw_variable_width_encoder_test.sv
// self-checking testbench for lzw_variable_width_encoder: bytes in, lzw codes out
// depends on lzwve_pkg and the encoder rtl; predicts every code from its own dictionary model
`timescale 1ns / 100ps

module lzw_variable_width_encoder_test;

	localparam int CODE_W         = lzwve_pkg::CODE_W;
	localparam int CWIDTH_W       = lzwve_pkg::CWIDTH_W;
	localparam int WATCHDOG_LIMIT = 8 * lzwve_pkg::MAX_CODES_DEF + 1000;
	localparam int RANDOM_BYTES   = 24;
	localparam int LONG_BYTES     = 270;

	logic                clk;
	logic                arst_n;
	logic                byte_valid;
	logic                byte_stall;
	logic [7:0]          data_byte;
	logic                end_of_input;
	logic                code_valid;
	logic                code_stall;
	logic [CODE_W-1:0]   code;
	logic [CWIDTH_W-1:0] code_width;
	logic                last_code;

	// predictor state
	logic [CODE_W-1:0]    cur_prefix;
	int unsigned          free_code;
	int unsigned          cur_width;
	int unsigned          pair_code [int unsigned];
	lzwve_pkg::out_item_t pending_codes [$];

	int  mismatches;
	int  idle_cycles;
	bit  no_idle;

	lzw_variable_width_encoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.code_valid   (code_valid),
		.code_stall   (code_stall),
		.code         (code),
		.code_width   (code_width),
		.last_code    (last_code)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_dictionary_model();
		pair_code.delete();
		free_code = lzwve_pkg::FIRST_FREE_CODE;
		cur_width = lzwve_pkg::FIRST_WIDTH;
	endfunction

	function automatic void expect_code(int unsigned c, int unsigned w, bit is_last);
		lzwve_pkg::out_item_t e;
		e.code       = c[CODE_W-1:0];
		e.code_width = w[CWIDTH_W-1:0];
		e.last_code  = is_last;
		pending_codes.push_back(e);
	endfunction

	function automatic void lzw_predict_byte(logic [7:0] b, logic eoi);
		int unsigned key;
		int unsigned hit;
		key = (int'(cur_prefix) << 8) | int'(b);
		if (cur_prefix == 0) begin
			hit = int'(b) + 1;
		end else if (pair_code.exists(key)) begin
			hit = pair_code[key];
		end else begin
			hit = 0;
		end
		if (hit != 0) begin
			cur_prefix = hit[CODE_W-1:0];
		end else begin
			expect_code(int'(cur_prefix), cur_width, 1'b0);
			if (free_code < lzwve_pkg::MAX_CODES_DEF)
				pair_code[key] = free_code;
			cur_prefix = CODE_W'(int'(b) + 1);
			free_code++;
			if (cur_width < 31 && free_code == (1 << cur_width))
				cur_width++;
			if (free_code >= lzwve_pkg::MAX_CODES_DEF)
				clear_dictionary_model();
		end
		if (eoi) begin
			expect_code(int'(cur_prefix), cur_width, 1'b0);
			expect_code(0, cur_width, 1'b1);
			cur_prefix = '0;
			clear_dictionary_model();
		end
	endfunction

	// input side: every accepted beat feeds the predictor
	always @(posedge clk) begin
		if (arst_n && byte_valid === 1'b1 && byte_stall === 1'b0)
			lzw_predict_byte(data_byte, end_of_input);
	end

	// output side: compare each accepted beat against the oldest expectation
	always @(posedge clk) begin : check_codes
		lzwve_pkg::out_item_t want;
		if (arst_n && code_valid === 1'b1 && code_stall === 1'b0) begin
			if (pending_codes.size() == 0) begin
				mismatches++;
				$display("%0t: expected no beat, actual code=%0d width=%0d last=%0b",
					$time, code, code_width, last_code);
			end else begin
				want = pending_codes.pop_front();
				if (code !== want.code || code_width !== want.code_width ||
						last_code !== want.last_code) begin
					mismatches++;
					// code/width/last
					$display("%0t: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
						$time, want.code, want.code_width, want.last_code,
						code, code_width, last_code);
				end
			end
		end
	end

	// ends the run if neither channel moves for too long (covers the ram sweep)
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((byte_valid === 1'b1 && byte_stall === 1'b0) ||
				(code_valid === 1'b1 && code_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("lzw_variable_width_encoder_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stall before each beat
	initial begin : drain_codes
		int hold;
		code_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 15);
			if (hold != 0) begin
				code_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			code_stall <= 1'b0;
			do @(posedge clk); while (code_valid !== 1'b1);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eoi);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid   <= 1'b1;
		data_byte    <= b;
		end_of_input <= eoi;
		do @(posedge clk); while (byte_stall !== 1'b0);
	endtask

	// one-byte streams: root hit, then prefix and end code; on their own too few
	// streams for the epoch tags to run out and the table to be swept
	task automatic test_lone_bytes();
		int i;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hA5, 1'b1);
		send_byte(8'h5A, 1'b1);
		for (i = 0; i < 8; i++)
			send_byte(8'($urandom), 1'b1);
	endtask

	// repeats and pairs: hits on stored strings, a miss on the last byte,
	// and a fresh dictionary after each end code
	task automatic test_short_streams();
		int i;
		no_idle = 1'b1;
		for (i = 0; i < 8; i++)
			send_byte(8'hFF, i == 7);
		no_idle = 1'b0;
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b1);
		for (i = 0; i < 8; i++)
			send_byte((i % 2) ? 8'h62 : 8'h61, i == 7);
	endtask

	// random streams, mostly over a few symbols so strings grow long
	task automatic test_random_streams();
		int sent;
		int len;
		int i;
		bit narrow;
		logic [7:0] sym [4];
		logic [7:0] b;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			len    = $urandom_range(1, 40);
			narrow = $urandom_range(0, 3) != 0;
			for (i = 0; i < 4; i++)
				sym[i] = 8'($urandom);
			no_idle = $urandom_range(0, 4) == 0;
			for (i = 0; i < len; i++) begin
				b = narrow ? sym[$urandom_range(0, 3)] : 8'($urandom);
				send_byte(b, i == len - 1);
			end
			sent += len;
		end
		no_idle = 1'b0;
	endtask

	// one long stream of random bytes: nearly every byte misses, so the width grows to 10
	task automatic test_width_growth();
		int i;
		for (i = 0; i < LONG_BYTES; i++) begin
			no_idle = $urandom_range(0, 7) == 0;
			send_byte(8'($urandom), i == LONG_BYTES - 1);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		data_byte    = '0;
		end_of_input = 1'b0;
		no_idle      = 1'b0;
		mismatches   = 0;
		cur_prefix   = '0;
		clear_dictionary_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_lone_bytes();
		test_short_streams();
		test_random_streams();
		test_width_growth();
		byte_valid <= 1'b0;

		while (pending_codes.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("lzw_variable_width_encoder_test: PASS");
		else
			$display("lzw_variable_width_encoder_test: FAIL");
		$finish;
	end

endmodule
